>>> rtl/core/bmt_pkg.sv
// shared constants, op and state codes, and the result record of the breakpoint match table
// no dependencies

package bmt_pkg;

   localparam int MAX_BREAKPOINTS = 16;
   localparam int IDX_W           = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
   localparam int CNT_W           = $clog2(MAX_BREAKPOINTS + 1);
   localparam int LAST_IDX        = MAX_BREAKPOINTS - 1;

   localparam int OP_W       = 2;
   localparam int FILE_W     = 8;
   localparam int LINE_W     = 16;
   localparam int COL_W      = 12;
   localparam int KEY_W      = FILE_W + LINE_W + COL_W;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = ((KEY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((COUNT_W + 3 + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_SET     = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_CHECK   = 2'd2,
      OP_REQUEST = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // packed so that hit lands in bit 0
   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
      logic               table_full;
      logic               do_break;
      logic               hit;
   } result_type;

endpackage

>>> rtl/core/bmt_key_ram.sv
// key store of the breakpoint match table: one write port, one registered read port
// depends on bmt_pkg

module bmt_key_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [bmt_pkg::IDX_W-1:0] wr_addr,
   input  logic [bmt_pkg::KEY_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [bmt_pkg::IDX_W-1:0] rd_addr,
   output logic [bmt_pkg::KEY_W-1:0] rd_data
);

   logic [bmt_pkg::KEY_W-1:0] mem_ff [bmt_pkg::MAX_BREAKPOINTS];
   logic [bmt_pkg::KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bmt_scan_ctrl.sv
// sequencer of the breakpoint match table: scans the key store, keeps valid bits,
// count and manual-break flag, and applies each operation; depends on bmt_pkg, bmt_key_ram

module bmt_scan_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  bmt_pkg::op_type            req_op,
   input  logic [bmt_pkg::KEY_W-1:0]  req_key,
   input  logic                       out_free,
   output logic                       res_valid,
   output bmt_pkg::result_type        res
);

   bmt_pkg::state_type                   state_ff, state_in;
   bmt_pkg::op_type                      op_ff, op_in;
   logic [bmt_pkg::KEY_W-1:0]            key_ff, key_in;
   logic [bmt_pkg::IDX_W-1:0]            scan_ff, scan_in;
   logic                                 cmp_vld_ff, cmp_vld_in;
   logic [bmt_pkg::IDX_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic                                 match_found_ff, match_found_in;
   logic [bmt_pkg::IDX_W-1:0]            match_idx_ff, match_idx_in;
   logic                                 free_found_ff, free_found_in;
   logic [bmt_pkg::IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [bmt_pkg::MAX_BREAKPOINTS-1:0]  valid_ff, valid_in;
   logic [bmt_pkg::CNT_W-1:0]            cnt_ff, cnt_in;
   logic                                 manual_ff, manual_in;

   logic                                 rd_en;
   logic [bmt_pkg::IDX_W-1:0]            rd_addr;
   logic [bmt_pkg::KEY_W-1:0]            rd_data;
   logic                                 wr_en;
   logic [bmt_pkg::IDX_W-1:0]            wr_addr;
   logic [bmt_pkg::KEY_W-1:0]            wr_data;
   logic                                 cmp_hit;
   logic                                 cmp_free;

   bmt_key_ram u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      scan_in        = scan_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      valid_in       = valid_ff;
      cnt_in         = cnt_ff;
      manual_in      = manual_ff;
      req_ready      = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = scan_ff;
      wr_en          = 1'b0;
      wr_addr        = free_idx_ff;
      wr_data        = key_ff;
      res_valid      = 1'b0;
      res            = '0;

      // entry read last cycle is compared now
      cmp_hit  = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_data == key_ff);
      cmp_free = cmp_vld_ff && !valid_ff[cmp_idx_ff];
      if (cmp_hit && !match_found_ff) begin
         match_found_in = 1'b1;
         match_idx_in   = cmp_idx_ff;
      end
      if (cmp_free && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = cmp_idx_ff;
      end

      unique case (state_ff)
         bmt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in          = req_op;
               key_in         = req_key;
               scan_in        = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               state_in       = bmt_pkg::ST_SCAN;
            end
         end
         bmt_pkg::ST_SCAN: begin
            rd_en      = 1'b1;
            cmp_vld_in = 1'b1;
            cmp_idx_in = scan_ff;
            if (scan_ff == bmt_pkg::IDX_W'(bmt_pkg::LAST_IDX)) begin
               state_in = bmt_pkg::ST_DRAIN;
            end else begin
               scan_in = bmt_pkg::IDX_W'(scan_ff + 1'b1);
            end
         end
         bmt_pkg::ST_DRAIN: begin
            state_in = bmt_pkg::ST_FINISH;
         end
         bmt_pkg::ST_FINISH: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = bmt_pkg::ST_IDLE;
               unique case (op_ff)
                  bmt_pkg::OP_SET: begin
                     if (match_found_ff) begin
                        res.hit = 1'b1;
                     end else if (free_found_ff) begin
                        wr_en                 = 1'b1;
                        valid_in[free_idx_ff] = 1'b1;
                        cnt_in                = bmt_pkg::CNT_W'(cnt_ff + 1'b1);
                     end else begin
                        res.table_full = 1'b1;
                     end
                  end
                  bmt_pkg::OP_CLEAR: begin
                     if (match_found_ff) begin
                        valid_in[match_idx_ff] = 1'b0;
                        if (cnt_ff != '0) begin
                           cnt_in = bmt_pkg::CNT_W'(cnt_ff - 1'b1);
                        end
                        res.hit = 1'b1;
                     end
                  end
                  bmt_pkg::OP_CHECK: begin
                     res.hit      = match_found_ff;
                     res.do_break = manual_ff || match_found_ff;
                     manual_in    = 1'b0;
                  end
                  bmt_pkg::OP_REQUEST: begin
                     manual_in = 1'b1;
                  end
               endcase
               res.entry_count = bmt_pkg::COUNT_W'(cnt_in);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bmt_pkg::ST_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
         cnt_ff     <= '0;
         manual_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
         cnt_ff     <= cnt_in;
         manual_ff  <= manual_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      scan_ff        <= scan_in;
      cmp_idx_ff     <= cmp_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
   end

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(cnt_ff))
      else $error("entry count differs from number of valid entries");

   a_write_to_free_slot: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == bmt_pkg::ST_FINISH) && !valid_ff[wr_addr])
      else $error("key store written outside finish or over a live entry");

   a_compare_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == bmt_pkg::ST_SCAN) || (state_ff == bmt_pkg::ST_DRAIN))
      else $error("compare active outside the scan");

endmodule

>>> rtl/core/breakpoint_match_table.sv
// top level of the breakpoint match table: stream ports and result register
// depends on bmt_pkg, bmt_scan_ctrl
//
// channel   direction  handshake              payload
// req_      in         req_tvalid/req_tready  tuser: operation; tdata: file_id, line, column
// rsp_      out        rsp_tvalid/rsp_tready  tdata: hit, do_break, table_full, entry_count
//
// an item is accepted in idle, then gets one key-store read per entry through the single read
// port in scan, its last compare in drain, and is applied in finish once the output register is free
// reset clears valid bits, count and manual flag at once; the key store is not cleared
// the result waits in an output register; the next item is accepted meanwhile and its
// finish step holds until that register is free

module breakpoint_match_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // file_id [7:0], line_number [23:8], column [35:24], zero [39:36]
   input  logic [bmt_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation [1:0]
   input  logic [bmt_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // hit [0], do_break [1], table_full [2], entry_count [7:3]
   output logic [bmt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                 rsp_valid_ff;
   bmt_pkg::result_type  rsp_res_ff;
   logic                 out_free;
   logic                 res_valid;
   bmt_pkg::result_type  res;

   assign out_free = !rsp_valid_ff || rsp_tready;

   bmt_scan_ctrl u_scan_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (bmt_pkg::op_type'(req_tuser)),
      .req_key   (req_tdata[bmt_pkg::KEY_W-1:0]),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bmt_pkg::RSP_DATA_W'(rsp_res_ff);

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an item not yet taken");

endmodule

>>> tb/bmt_checker.sv
// checker for the breakpoint match table: watches both stream channels, keeps its own copy
// of the breakpoint table, predicts each result and compares it field by field
// depends on bmt_pkg

module bmt_checker
   import bmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // file_id [7:0], line_number [23:8], column [35:24], zero [39:36]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation [1:0]
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit [0], do_break [1], table_full [2], entry_count [7:3]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    failures,
   output int                    outstanding
);

   bit               slot_used[MAX_BREAKPOINTS];
   logic [KEY_W-1:0] slot_key[MAX_BREAKPOINTS];
   int unsigned      live_count = 0;
   bit               manual_pending = 1'b0;
   result_type       expected_results[$];
   int               results_seen = 0;
   int               fail_count = 0;
   int               pending_count = 0;

   assign failures    = fail_count;
   assign outstanding = pending_count;

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      fail_count++;
   endtask

   function automatic result_type apply_breakpoint_op(input op_type op,
                                                      input logic [KEY_W-1:0] key);
      int         match_at;
      int         free_at;
      result_type res;
      match_at = -1;
      free_at  = -1;
      for (int i = MAX_BREAKPOINTS - 1; i >= 0; i--) begin
         if (slot_used[i] && slot_key[i] == key) match_at = i;
         if (!slot_used[i]) free_at = i;
      end
      res = '0;
      case (op)
         OP_SET: begin
            if (match_at >= 0) begin
               res.hit = 1'b1;
            end else if (free_at >= 0) begin
               slot_used[free_at] = 1'b1;
               slot_key[free_at]  = key;
               live_count++;
            end else begin
               res.table_full = 1'b1;
            end
         end
         OP_CLEAR: begin
            if (match_at >= 0) begin
               slot_used[match_at] = 1'b0;
               if (live_count > 0) live_count--;
               res.hit = 1'b1;
            end
         end
         OP_CHECK: begin
            res.hit        = (match_at >= 0);
            res.do_break   = manual_pending || (match_at >= 0);
            manual_pending = 1'b0;
         end
         default: begin
            manual_pending = 1'b1;
         end
      endcase
      res.entry_count = COUNT_W'(live_count);
      return res;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_BREAKPOINTS; i++) slot_used[i] = 1'b0;
         live_count     = 0;
         manual_pending = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("item %h with nothing expected", rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (got.hit !== want.hit)
                  report_mismatch($sformatf("hit got %0d want %0d", got.hit, want.hit));
               if (got.do_break !== want.do_break)
                  report_mismatch($sformatf("do_break got %0d want %0d",
                                            got.do_break, want.do_break));
               if (got.table_full !== want.table_full)
                  report_mismatch($sformatf("table_full got %0d want %0d",
                                            got.table_full, want.table_full));
               if (got.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            got.entry_count, want.entry_count));
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_breakpoint_op(op_type'(req_tuser),
                                                           req_tdata[KEY_W-1:0]));
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

>>> tb/tb.sv
// testbench top for the breakpoint match table: clock, reset, directed and random items,
// random stalls on both channels and the final verdict
// depends on bmt_pkg, breakpoint_match_table and bmt_checker

module tb;
   import bmt_pkg::*;

   localparam int POOL_SIZE    = 20;
   localparam int RANDOM_ITEMS = 1900;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    failures;
   int                    outstanding;
   logic [KEY_W-1:0]      key_pool[POOL_SIZE];

   always #2 clock = ~clock;

   breakpoint_match_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bmt_checker table_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   task automatic send_item(input op_type op, input logic [KEY_W-1:0] key, input bit calm);
      int                    gap;
      logic [REQ_DATA_W-1:0] word;
      gap = calm ? 0 : $urandom_range(0, 11);
      word = '0;
      word[KEY_W-1:0] = key;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   initial begin
      logic [KEY_W-1:0] key;
      op_type           op;
      int               roll;
      bit               filling;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {4'($urandom), 32'($urandom)};
      key_pool[0]             = '0;
      key_pool[POOL_SIZE - 1] = '1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // manual break on an empty table, sticky over two requests
      send_item(OP_CHECK, '0, 1'b0);
      send_item(OP_REQUEST, '0, 1'b0);
      send_item(OP_REQUEST, '1, 1'b0);
      send_item(OP_CHECK, '1, 1'b0);
      send_item(OP_CHECK, '1, 1'b0);
      // extreme keys, duplicate set, match together with a pending request
      send_item(OP_SET, key_pool[0], 1'b0);
      send_item(OP_SET, key_pool[POOL_SIZE - 1], 1'b0);
      send_item(OP_SET, key_pool[POOL_SIZE - 1], 1'b0);
      send_item(OP_REQUEST, key_pool[3], 1'b0);
      send_item(OP_CHECK, key_pool[POOL_SIZE - 1], 1'b0);
      send_item(OP_CLEAR, key_pool[16], 1'b0);
      // fill the table, then overflow it
      for (int i = 1; i <= 14; i++) send_item(OP_SET, key_pool[i], 1'b0);
      send_item(OP_SET, key_pool[15], 1'b0);
      send_item(OP_CLEAR, key_pool[0], 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         filling = ((n / 120) % 2) == 0;
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 55 : 15)) op = OP_SET;
         else if (roll < (filling ? 65 : 60)) op = OP_CLEAR;
         else if (roll < 90) op = OP_CHECK;
         else op = OP_REQUEST;
         key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         roll = $urandom_range(0, 99);
         if (roll >= 85) key = {4'($urandom), 32'($urandom)};
         else if (roll >= 70) key[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
         send_item(op, key, ((n / 150) % 4) == 3);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      int taken;
      int gap;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT) gap = HOLD_CYCLES;
         else if (((taken / 130) % 5) == 2) gap = 0;
         else gap = $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   initial begin
      #(4 * 800_000);
      $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/bmt_pkg.sv
rtl/core/bmt_key_ram.sv
rtl/core/bmt_scan_ctrl.sv
rtl/core/breakpoint_match_table.sv
tb/bmt_checker.sv
tb/tb.sv
